FILE: design/pressure_temperature_compensation_assert.svh
// assertion macros shared by the compensation rtl
// expects clk and rst in scope of the including module
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// condition must never hold outside reset
`define PTC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ptc assertion failed: forbidden condition");

// antecedent implies consequent in the same cycle
`define PTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptc assertion failed: implication");

`endif

FILE: design/ptc_pkg.sv
// shared types, constants and multiply helpers for the compensation block
// no dependencies
package ptc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DIV_STEPS   = 64;
  localparam int DEN_W       = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CAL_W       = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 2'd3;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // request handed from front to back
  typedef struct packed {
    logic [31:0]      temp;
    logic [63:0]      num;
    logic [DEN_W-1:0] den;
  } front_item_t;

  // sideband carried through the divider
  typedef struct packed {
    logic [31:0] temp;
    logic        neg;
    logic        zero;
  } side_t;

  localparam int FRONT_ITEM_W = $bits(front_item_t);

  // low half of a 64 x signed 16 product: unsigned low word times c
  function automatic logic signed [48:0] mul_lo(logic [31:0] x, logic [15:0] c);
    mul_lo = $signed({1'b0, x}) * $signed(c);
  endfunction

  // high word times c, only 32 bits survive the wrap
  function automatic logic [31:0] mul_hi(logic [31:0] x, logic [15:0] c);
    mul_hi = x * {{16{c[15]}}, c};
  endfunction

  function automatic logic [63:0] mul_join(logic signed [48:0] lo, logic [31:0] hi);
    mul_join = {{15{lo[48]}}, lo} + {hi, 32'd0};
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] c);
    sext16 = {{48{c[15]}}, c};
  endfunction

endpackage

FILE: design/pressure_temperature_compensation.sv
// latency: 80 cycles from accepted sample to result, more while pop is held low
// throughput: one sample pair per cycle, set by the credit of the front/back queue
// (a request holds a credit for 11 cycles, so QUEUE_DEPTH must be at least 12 for full rate)
// reset: synchronous, clears calibration registers, queue pointers, credits and valids
// top level: calibration registers, credit counter, front, queue, back
// uses ptc_pkg, ptc_front, ptc_queue, ptc_back
module pressure_temperature_compensation #(
  parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [19:0]                     raw_temperature,
  input  logic [19:0]                     raw_pressure,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [31:0]              temperature_centi,
  output logic [31:0]                     pressure_q24_8,
  output logic                            pressure_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptc_pkg::CAL_W-1:0]       cfg_data
);
  import ptc_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CAL_W-1:0] temp_calibration;
  logic [CAL_W-1:0] press_calibration_a;
  logic [CAL_W-1:0] press_calibration_b;
  logic [CAL_W-1:0] press_calibration_c;
  cal_t cal;

  logic [CW-1:0] credit;
  logic accept;
  logic f_valid;
  front_item_t f_item;
  logic q_valid, q_pop;
  logic [FRONT_ITEM_W-1:0] q_rdata;
  logic b_valid;
  logic [31:0] temp_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calibration    <= '0;
      press_calibration_a <= '0;
      press_calibration_b <= '0;
      press_calibration_c <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMP:    temp_calibration    <= cfg_data;
        CFG_PRESS_A: press_calibration_a <= cfg_data;
        CFG_PRESS_B: press_calibration_b <= cfg_data;
        CFG_PRESS_C: press_calibration_c <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cal.t1 = temp_calibration[15:0];
  assign cal.t2 = temp_calibration[31:16];
  assign cal.t3 = temp_calibration[47:32];
  assign cal.p1 = press_calibration_a[15:0];
  assign cal.p2 = press_calibration_a[31:16];
  assign cal.p3 = press_calibration_a[47:32];
  assign cal.p4 = press_calibration_b[15:0];
  assign cal.p5 = press_calibration_b[31:16];
  assign cal.p6 = press_calibration_b[47:32];
  assign cal.p7 = press_calibration_c[15:0];
  assign cal.p8 = press_calibration_c[31:16];
  assign cal.p9 = press_calibration_c[47:32];

  // credits cover requests in the front and in the queue, so the front never stalls
  assign full   = (credit == CW'(QUEUE_DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CW'(accept) - CW'(q_pop);
    end
  end

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .raw_t     (raw_temperature),
    .raw_p     (raw_pressure),
    .cal       (cal),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  ptc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .wdata (f_item),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  ptc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (q_valid),
    .in_item           (front_item_t'(q_rdata)),
    .cal               (cal),
    .take              (q_pop),
    .out_valid         (b_valid),
    .pop               (pop),
    .temperature_centi (temp_out),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_valid    (pressure_valid)
  );

  assign empty             = !b_valid;
  assign temperature_centi = $signed(temp_out);

`include "pressure_temperature_compensation_assert.svh"
  `PTC_ASSERT_NEVER(a_credit_range, credit > CW'(QUEUE_DEPTH))
  `PTC_ASSERT_NEVER(a_queue_without_credit, q_valid && credit == '0)
  `PTC_ASSERT_IMPL(a_zero_divisor_result, !empty && !pressure_valid, pressure_q24_8 == 32'd0)

endmodule

FILE: design/ptc_queue.sv
// small fifo between front and back
// uses ptc_pkg for the item width
module ptc_queue #(
  parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [ptc_pkg::FRONT_ITEM_W-1:0] wdata,
  input  logic                           pop,
  output logic                           valid,
  output logic [ptc_pkg::FRONT_ITEM_W-1:0] rdata
);
  import ptc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [FRONT_ITEM_W-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign valid = (count != '0);
  assign rdata = mem[rp];

`include "pressure_temperature_compensation_assert.svh"
  `PTC_ASSERT_NEVER(a_q_overflow, push && !pop && count == CW'(DEPTH))
  `PTC_ASSERT_NEVER(a_q_underflow, pop && count == '0)
  `PTC_ASSERT_NEVER(a_q_count_range, count > CW'(DEPTH))

endmodule

FILE: design/ptc_front.sv
// front pipeline: temperature, fine temperature, numerator and divisor
// uses ptc_pkg; free running, one sample per cycle
module ptc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [19:0]          raw_t,
  input  logic [19:0]          raw_p,
  input  ptc_pkg::cal_t        cal,
  output logic                 out_valid,
  output ptc_pkg::front_item_t out_item
);
  import ptc_pkg::*;

  logic [9:0] v;

  // stage 0
  logic [19:0] adc_t0, adc_p0;
  // stage 1
  logic [31:0] m1, m2;
  logic [19:0] adc_p1;
  // stage 2
  logic [31:0] tv1, m3;
  logic [19:0] adc_p2;
  // stage 3
  logic [31:0] t_fine;
  logic [19:0] adc_p3;
  // stage 4
  logic [31:0] temp4;
  logic signed [32:0] dv4;
  logic [19:0] adc_p4;
  // stage 5
  logic [63:0] sq5;
  logic signed [48:0] q5_5, q2_5;
  logic [31:0] temp5;
  logic [19:0] adc_p5;
  // stage 6
  logic signed [48:0] a6lo, a3lo, q5_6, q2_6;
  logic [31:0] a6hi, a3hi, temp6;
  logic [19:0] adc_p6;
  // stage 7
  logic [63:0] v2_7, w7;
  logic [31:0] temp7;
  logic [19:0] adc_p7;
  // stage 8
  logic [47:0] xlo8;
  logic [31:0] xhi8, temp8;
  logic [63:0] n8;
  // stage 9
  front_item_t item9;

  logic [31:0] d1, d2, t2x, t3x, m2s, t5;
  logic signed [65:0] sqf;
  logic [63:0] v2c, wc, xc, prodc;
  logic [20:0] pdiff;

  always_comb begin
    d1    = 32'(adc_t0 >> 3) - {15'd0, cal.t1, 1'b0};
    d2    = 32'(adc_t0 >> 4) - {16'd0, cal.t1};
    t2x   = {{16{cal.t2[15]}}, cal.t2};
    t3x   = {{16{cal.t3[15]}}, cal.t3};
    m2s   = 32'($signed(m2) >>> 12);
    t5    = t_fine * 32'd5 + 32'd128;
    sqf   = dv4 * dv4;
    v2c   = mul_join(a6lo, a6hi) + (64'(q5_6) << 17) + (sext16(cal.p4) << 35);
    wc    = 64'($signed(mul_join(a3lo, a3hi)) >>> 8) + (64'(q2_6) << 12);
    xc    = 64'h0000_8000_0000_0000 + w7;
    pdiff = 21'd1048576 - {1'b0, adc_p7};
    prodc = {16'd0, xlo8} + {xhi8, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    adc_t0 <= raw_t;
    adc_p0 <= raw_p;

    m1     <= d1 * t2x;
    m2     <= d2 * d2;
    adc_p1 <= adc_p0;

    tv1    <= 32'($signed(m1) >>> 11);
    m3     <= m2s * t3x;
    adc_p2 <= adc_p1;

    t_fine <= tv1 + 32'($signed(m3) >>> 14);
    adc_p3 <= adc_p2;

    temp4  <= 32'($signed(t5) >>> 8);
    dv4    <= $signed({t_fine[31], t_fine}) - 33'sd128000;
    adc_p4 <= adc_p3;

    sq5    <= sqf[63:0];
    q5_5   <= dv4 * $signed(cal.p5);
    q2_5   <= dv4 * $signed(cal.p2);
    temp5  <= temp4;
    adc_p5 <= adc_p4;

    a6lo   <= mul_lo(sq5[31:0], cal.p6);
    a6hi   <= mul_hi(sq5[63:32], cal.p6);
    a3lo   <= mul_lo(sq5[31:0], cal.p3);
    a3hi   <= mul_hi(sq5[63:32], cal.p3);
    q5_6   <= q5_5;
    q2_6   <= q2_5;
    temp6  <= temp5;
    adc_p6 <= adc_p5;

    v2_7   <= v2c;
    w7     <= wc;
    temp7  <= temp6;
    adc_p7 <= adc_p6;

    xlo8   <= xc[31:0] * cal.p1;
    xhi8   <= xc[63:32] * {16'd0, cal.p1};
    n8     <= ({43'd0, pdiff} << 31) - v2_7;
    temp8  <= temp7;

    // divisor is the product shifted right by 33, which leaves 31 bits
    item9.den  <= prodc[63:33];
    item9.num  <= n8 * 64'd3125;
    item9.temp <= temp8;
  end

  assign out_valid = v[9];
  assign out_item  = item9;

endmodule

FILE: design/ptc_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// uses ptc_pkg; all stages advance together on en
module ptc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [63:0]                 an,
  input  logic [ptc_pkg::DEN_W-1:0]   ad,
  input  ptc_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [63:0]                 quo,
  output ptc_pkg::side_t              out_side
);
  import ptc_pkg::*;

  logic             v    [DIV_STEPS];
  logic [DEN_W-1:0] rem  [DIV_STEPS];
  logic [63:0]      num  [DIV_STEPS];
  logic [DEN_W-1:0] dr   [DIV_STEPS];
  side_t            side [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic             pv;
    logic [DEN_W-1:0] prem, pad;
    logic [63:0]      pnum;
    side_t            pside;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign pad   = ad;
      assign pnum  = an;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v[i-1];
      assign prem  = rem[i-1];
      assign pad   = dr[i-1];
      assign pnum  = num[i-1];
      assign pside = side[i-1];
    end

    // remainder stays below the divisor, so it fits the divisor width
    assign trial = {prem, pnum[63]};
    assign ge    = (trial >= {1'b0, pad});
    assign diff  = trial - {1'b0, pad};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num[i]  <= {pnum[62:0], ge};
        dr[i]   <= pad;
        side[i] <= pside;
      end
    end
  end

  assign out_valid = v[DIV_STEPS-1];
  assign quo       = num[DIV_STEPS-1];
  assign out_side  = side[DIV_STEPS-1];

endmodule

FILE: design/ptc_back.sv
// back pipeline: signed divide, second order pressure terms, result register
// uses ptc_pkg and ptc_div; stalls as a whole when the result is not taken
module ptc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ptc_pkg::front_item_t in_item,
  input  ptc_pkg::cal_t        cal,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 pop,
  output logic [31:0]          temperature_centi,
  output logic [31:0]          pressure_q24_8,
  output logic                 pressure_valid
);
  import ptc_pkg::*;

  logic adv;

  logic             b0_v;
  logic [63:0]      an0;
  logic [DEN_W-1:0] ad0;
  side_t            side0;

  logic        dv_v;
  logic [63:0] dquo;
  side_t       dside;

  logic        b1_v, b2_v, b3_v, b4_v, o_v;
  logic [63:0] p1r, p2r, p3r, p4r;
  side_t       s1, s2, s3, s4;
  logic [63:0] lolo2;
  logic [31:0] cr2, p8hi2, p9hi4;
  logic signed [48:0] p8lo2, p9lo4;
  logic [63:0] aa3, b8_3, b8_4;
  logic [63:0] ac, v1c, prc;

  assign adv  = !o_v || pop;
  assign take = adv && in_valid;

  always_comb begin
    ac  = 64'($signed(p1r) >>> 13);
    v1c = 64'($signed(mul_join(p9lo4, p9hi4)) >>> 25);
    prc = 64'($signed(p4r + v1c + b8_4) >>> 8) + (sext16(cal.p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (adv) begin
      b0_v <= in_valid;
      b1_v <= dv_v;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      o_v  <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // sign and magnitude split ahead of the divider
      an0        <= in_item.num[63] ? 64'd0 - in_item.num : in_item.num;
      ad0        <= in_item.den[DEN_W-1] ? DEN_W'(0) - in_item.den : in_item.den;
      side0.neg  <= in_item.num[63] ^ in_item.den[DEN_W-1];
      side0.zero <= (in_item.den == '0);
      side0.temp <= in_item.temp;

      p1r <= dside.neg ? 64'd0 - dquo : dquo;
      s1  <= dside;

      lolo2 <= ac[31:0] * ac[31:0];
      cr2   <= ac[31:0] * ac[63:32];
      p8lo2 <= mul_lo(p1r[31:0], cal.p8);
      p8hi2 <= mul_hi(p1r[63:32], cal.p8);
      p2r   <= p1r;
      s2    <= s1;

      // both cross terms are equal, so one product shifted by one
      aa3  <= lolo2 + {cr2 << 1, 32'd0};
      b8_3 <= 64'($signed(mul_join(p8lo2, p8hi2)) >>> 19);
      p3r  <= p2r;
      s3   <= s2;

      p9lo4 <= mul_lo(aa3[31:0], cal.p9);
      p9hi4 <= mul_hi(aa3[63:32], cal.p9);
      b8_4  <= b8_3;
      p4r   <= p3r;
      s4    <= s3;

      temperature_centi <= s4.temp;
      pressure_q24_8    <= s4.zero ? 32'd0 : prc[31:0];
      pressure_valid    <= !s4.zero;
    end
  end

  ptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b0_v),
    .an        (an0),
    .ad        (ad0),
    .in_side   (side0),
    .out_valid (dv_v),
    .quo       (dquo),
    .out_side  (dside)
  );

  assign out_valid = o_v;

endmodule
